/* hw/rtl/bdc_pkg.sv */
`timescale 1ns / 1ps
// Shared constants, command codes and the controller-to-datapath command word
// for the de Casteljau Bezier evaluator. No dependencies.

package bdc_pkg;

    // Defaults for the top-level parameters
    localparam int MAX_POINTS_DEF  = 8;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;

    // Slot/level fields in the command word; wide enough for 16 points
    localparam int SLOT_W = 4;

    // Fixed port widths
    localparam int CMD_W   = 2;
    localparam int PIDX_W  = 3;
    localparam int PARAM_W = 17;
    localparam int DEG_W   = 3;
    localparam int PNUM_W  = 3;

    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EVAL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SPLIT = 2'd2;

    localparam logic [DEG_W-1:0] DEGREE_RST = 3'd3;

    // Controller to datapath command word
    typedef struct packed {
        logic              wr_pt;      // store the input point
        logic [SLOT_W-1:0] wr_slot;
        logic              t_load;     // capture and clamp the curve parameter
        logic              issue;      // launch one interpolation step
        logic              src_ctrl;   // step copies a control point (level 0)
        logic [SLOT_W-1:0] rd_k;
        logic [SLOT_W-1:0] tag_level;
        logic              tag_first;  // result feeds the left subcurve
        logic              tag_last;   // result feeds the right subcurve
        logic              emit;       // load the output register
        logic              emit_side;
        logic [SLOT_W-1:0] emit_idx;
        logic [SLOT_W-1:0] emit_num;
        logic              emit_last;
    } dp_cmd_t;

endpackage

/* hw/rtl/bdc_lane.sv */
`timescale 1ns / 1ps
// One coordinate lane: control point store, scratch triangle memory,
// three-stage interpolation pipeline and subcurve capture. Uses bdc_pkg.

module bdc_lane
    import bdc_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [SLOT_W-1:0]      wr_slot,
    input  logic [COORD_WIDTH-1:0] wr_data,
    input  logic                   rd_src_ctrl,
    input  logic [SLOT_W-1:0]      rd_k,
    input  logic [FRAC_BITS:0]     t_val,
    input  logic                   wb_en,
    input  logic [SLOT_W-1:0]      wb_k,
    input  logic [SLOT_W-1:0]      wb_level,
    input  logic                   wb_first,
    input  logic                   wb_last,
    input  logic                   emit,
    input  logic                   emit_side,
    input  logic [SLOT_W-1:0]      emit_idx,
    output logic [COORD_WIDTH-1:0] coord_out
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int TW = FRAC_BITS + 1;
    localparam int PW = COORD_WIDTH + TW + 2;

    logic [COORD_WIDTH-1:0]        ctrl_pt_reg [MAX_POINTS];
    logic [COORD_WIDTH-1:0]        work_mem    [MAX_POINTS];
    logic [COORD_WIDTH-1:0]        left_reg    [MAX_POINTS];
    logic [COORD_WIDTH-1:0]        right_reg   [MAX_POINTS];

    logic [COORD_WIDTH-1:0]        a_reg;
    logic [COORD_WIDTH-1:0]        b_reg;
    logic signed [COORD_WIDTH:0]   d_reg;
    logic [COORD_WIDTH-1:0]        p2_reg;
    logic signed [PW-1:0]          prod_reg;
    logic [COORD_WIDTH-1:0]        p3_reg;
    logic [COORD_WIDTH-1:0]        out_reg;

    logic [IW-1:0]                 ka;
    logic [IW-1:0]                 kb;
    logic signed [TW:0]            t_s;
    logic [COORD_WIDTH:0]          step;
    logic [COORD_WIDTH:0]          sum;
    logic [COORD_WIDTH-1:0]        lerp_res;

    assign ka  = rd_k[IW-1:0];
    assign kb  = ka + IW'(1);
    assign t_s = $signed({1'b0, t_val});

    // floor((q - p) * t / 2^F) is an arithmetic shift of the product
    assign step     = prod_reg[FRAC_BITS+COORD_WIDTH:FRAC_BITS];
    assign sum      = {p3_reg[COORD_WIDTH-1], p3_reg} + step;
    assign lerp_res = sum[COORD_WIDTH-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_POINTS; i++)
            begin
                ctrl_pt_reg[i] <= '0;
            end
        end
        else if (wr_en)
        begin
            ctrl_pt_reg[wr_slot[IW-1:0]] <= wr_data;
        end
    end

    // Operand fetch; a copy step reads the same control point twice so d is zero
    always_ff @(posedge clk)
    begin
        a_reg <= rd_src_ctrl ? ctrl_pt_reg[ka] : work_mem[ka];
        b_reg <= rd_src_ctrl ? ctrl_pt_reg[ka] : work_mem[kb];
    end

    always_ff @(posedge clk)
    begin
        d_reg    <= $signed({b_reg[COORD_WIDTH-1], b_reg})
                    - $signed({a_reg[COORD_WIDTH-1], a_reg});
        p2_reg   <= a_reg;
        prod_reg <= PW'(d_reg) * PW'(t_s);
        p3_reg   <= p2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (wb_en)
        begin
            work_mem[wb_k[IW-1:0]] <= lerp_res;
            if (wb_first)
            begin
                left_reg[wb_level[IW-1:0]] <= lerp_res;
            end
            if (wb_last)
            begin
                right_reg[wb_k[IW-1:0]] <= lerp_res;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_reg <= emit_side ? right_reg[emit_idx[IW-1:0]] : left_reg[emit_idx[IW-1:0]];
        end
    end

    assign coord_out = out_reg;

endmodule

/* hw/rtl/bdc_datapath.sv */
`timescale 1ns / 1ps
// Datapath: parameter register, step tag pipeline, three coordinate lanes
// and the output register. Uses bdc_pkg and bdc_lane.

module bdc_datapath
    import bdc_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  dp_cmd_t                dp_cmd,
    input  logic [COORD_WIDTH-1:0] coord_x,
    input  logic [COORD_WIDTH-1:0] coord_y,
    input  logic [COORD_WIDTH-1:0] coord_z,
    input  logic [PARAM_W-1:0]     curve_param,
    output logic                   pipe_busy,
    output logic                   result_valid,
    output logic [COORD_WIDTH-1:0] out_x,
    output logic [COORD_WIDTH-1:0] out_y,
    output logic [COORD_WIDTH-1:0] out_z,
    output logic                   curve_side,
    output logic [PNUM_W-1:0]      point_number,
    output logic                   last
);

    localparam int TW  = FRAC_BITS + 1;
    localparam int TCW = (TW > PARAM_W) ? TW : PARAM_W;
    localparam logic [TCW-1:0] T_ONE = TCW'(64'd1 << FRAC_BITS);

    typedef struct packed {
        logic [SLOT_W-1:0] k;
        logic [SLOT_W-1:0] level;
        logic              first;
        logic              last;
    } tag_t;

    logic [TW-1:0]     t_reg;
    logic [TW-1:0]     t_next;
    logic              s1_v_reg;
    logic              s2_v_reg;
    logic              s3_v_reg;
    tag_t              s1_tag_reg;
    tag_t              s2_tag_reg;
    tag_t              s3_tag_reg;
    tag_t              s1_tag_next;
    logic              valid_reg;
    logic              side_reg;
    logic [PNUM_W-1:0] num_reg;
    logic              last_reg;

    // Clamp t to 1.0
    always_comb
    begin
        t_next = t_reg;
        if (dp_cmd.t_load)
        begin
            t_next = (TCW'(curve_param) > T_ONE) ? TW'(T_ONE) : TW'(curve_param);
        end
    end

    assign s1_tag_next = '{k: dp_cmd.rd_k, level: dp_cmd.tag_level,
                           first: dp_cmd.tag_first, last: dp_cmd.tag_last};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg  <= 1'b0;
            s2_v_reg  <= 1'b0;
            s3_v_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            s1_v_reg  <= dp_cmd.issue;
            s2_v_reg  <= s1_v_reg;
            s3_v_reg  <= s2_v_reg;
            valid_reg <= dp_cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg      <= t_next;
        s1_tag_reg <= s1_tag_next;
        s2_tag_reg <= s1_tag_reg;
        s3_tag_reg <= s2_tag_reg;
        if (dp_cmd.emit)
        begin
            side_reg <= dp_cmd.emit_side;
            num_reg  <= PNUM_W'(dp_cmd.emit_num);
            last_reg <= dp_cmd.emit_last;
        end
    end

    assign pipe_busy = s1_v_reg | s2_v_reg | s3_v_reg;

    bdc_lane #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_lane_x (
        .clk(clk), .rst_n(rst_n),
        .wr_en(dp_cmd.wr_pt), .wr_slot(dp_cmd.wr_slot), .wr_data(coord_x),
        .rd_src_ctrl(dp_cmd.src_ctrl), .rd_k(dp_cmd.rd_k), .t_val(t_reg),
        .wb_en(s3_v_reg), .wb_k(s3_tag_reg.k), .wb_level(s3_tag_reg.level),
        .wb_first(s3_tag_reg.first), .wb_last(s3_tag_reg.last),
        .emit(dp_cmd.emit), .emit_side(dp_cmd.emit_side), .emit_idx(dp_cmd.emit_idx),
        .coord_out(out_x)
    );

    bdc_lane #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_lane_y (
        .clk(clk), .rst_n(rst_n),
        .wr_en(dp_cmd.wr_pt), .wr_slot(dp_cmd.wr_slot), .wr_data(coord_y),
        .rd_src_ctrl(dp_cmd.src_ctrl), .rd_k(dp_cmd.rd_k), .t_val(t_reg),
        .wb_en(s3_v_reg), .wb_k(s3_tag_reg.k), .wb_level(s3_tag_reg.level),
        .wb_first(s3_tag_reg.first), .wb_last(s3_tag_reg.last),
        .emit(dp_cmd.emit), .emit_side(dp_cmd.emit_side), .emit_idx(dp_cmd.emit_idx),
        .coord_out(out_y)
    );

    bdc_lane #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_lane_z (
        .clk(clk), .rst_n(rst_n),
        .wr_en(dp_cmd.wr_pt), .wr_slot(dp_cmd.wr_slot), .wr_data(coord_z),
        .rd_src_ctrl(dp_cmd.src_ctrl), .rd_k(dp_cmd.rd_k), .t_val(t_reg),
        .wb_en(s3_v_reg), .wb_k(s3_tag_reg.k), .wb_level(s3_tag_reg.level),
        .wb_first(s3_tag_reg.first), .wb_last(s3_tag_reg.last),
        .emit(dp_cmd.emit), .emit_side(dp_cmd.emit_side), .emit_idx(dp_cmd.emit_idx),
        .coord_out(out_z)
    );

    assign result_valid = valid_reg;
    assign curve_side   = side_reg;
    assign point_number = num_reg;
    assign last         = last_reg;

    a_busy_from_issue: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pipe_busy) |-> $past(dp_cmd.issue))
        else $error("pipeline filled without an issued step");

    a_no_emit_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s3_v_reg |-> !dp_cmd.emit)
        else $error("output loaded while a step is still writing back");

endmodule

/* hw/rtl/bdc_ctrl.sv */
`timescale 1ns / 1ps
// Controller: degree register, command decode and the sequencer that walks
// the de Casteljau triangle and the result readout. Uses bdc_pkg.

module bdc_ctrl
    import bdc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CMD_W-1:0]  cmd,
    input  logic [PIDX_W-1:0] point_index,
    input  logic              cfg_wr_en,
    input  logic [DEG_W-1:0]  cfg_wr_data,
    input  logic              pipe_busy,
    output logic              busy,
    output dp_cmd_t           dp_cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_EMIT  = 2'd3;

    localparam logic [SLOT_W-1:0] TOP_SLOT = SLOT_W'(MAX_POINTS - 1);

    logic [1:0]        state_reg,  state_next;
    logic [DEG_W-1:0]  degree_reg, degree_next;
    logic [SLOT_W-1:0] n_reg,      n_next;
    logic [SLOT_W-1:0] level_reg,  level_next;
    logic [SLOT_W-1:0] k_reg,      k_next;
    logic              split_reg,  split_next;
    logic              side_reg,   side_next;

    logic [SLOT_W-1:0] deg_sat;
    logic              slot_ok;

    assign deg_sat = (SLOT_W'(degree_reg) > TOP_SLOT) ? TOP_SLOT : SLOT_W'(degree_reg);
    assign slot_ok = (SLOT_W'(point_index) <= TOP_SLOT);
    assign busy    = (state_reg != ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        degree_next = cfg_wr_en ? cfg_wr_data : degree_reg;
        n_next      = n_reg;
        level_next  = level_reg;
        k_next      = k_reg;
        split_next  = split_reg;
        side_next   = side_reg;
        dp_cmd         = '0;
        dp_cmd.wr_slot = SLOT_W'(point_index);

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd)
                        CMD_WRITE:
                        begin
                            dp_cmd.wr_pt = slot_ok;
                        end
                        CMD_EVAL, CMD_SPLIT:
                        begin
                            dp_cmd.t_load = 1'b1;
                            n_next        = deg_sat;
                            level_next    = '0;
                            k_next        = '0;
                            split_next    = (cmd == CMD_SPLIT);
                            state_next    = ST_ISSUE;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_ISSUE:
            begin
                dp_cmd.issue     = 1'b1;
                dp_cmd.src_ctrl  = (level_reg == '0);
                dp_cmd.rd_k      = k_reg;
                dp_cmd.tag_level = level_reg;
                dp_cmd.tag_first = (k_reg == '0);
                dp_cmd.tag_last  = (k_reg == n_reg - level_reg);
                if (dp_cmd.tag_last)
                begin
                    k_next     = '0;
                    state_next = ST_DRAIN;
                end
                else
                begin
                    k_next = k_reg + 1'b1;
                end
            end

            ST_DRAIN:
            begin
                if (!pipe_busy)
                begin
                    if (level_reg == n_reg)
                    begin
                        k_next     = '0;
                        side_next  = 1'b0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        level_next = level_reg + 1'b1;
                        state_next = ST_ISSUE;
                    end
                end
            end

            ST_EMIT:
            begin
                dp_cmd.emit = 1'b1;
                if (split_reg)
                begin
                    dp_cmd.emit_side = side_reg;
                    dp_cmd.emit_idx  = k_reg;
                    dp_cmd.emit_num  = k_reg;
                    dp_cmd.emit_last = side_reg && (k_reg == n_reg);
                    if (k_reg == n_reg)
                    begin
                        k_next = '0;
                        if (side_reg)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            side_next = 1'b1;
                        end
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
                else
                begin
                    dp_cmd.emit_idx  = n_reg;
                    dp_cmd.emit_last = 1'b1;
                    state_next       = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            degree_reg <= DEGREE_RST;
            n_reg      <= '0;
            level_reg  <= '0;
            k_reg      <= '0;
            split_reg  <= 1'b0;
            side_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            degree_reg <= degree_next;
            n_reg      <= n_next;
            level_reg  <= level_next;
            k_reg      <= k_next;
            split_reg  <= split_next;
            side_reg   <= side_next;
        end
    end

    a_step_in_triangle: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.issue |-> (({1'b0, dp_cmd.rd_k} + {1'b0, dp_cmd.tag_level}) <= {1'b0, n_reg}))
        else $error("step outside the triangle");

    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.emit |-> !pipe_busy)
        else $error("readout started before the pipeline drained");

    a_last_ends_item: assert property (@(posedge clk) disable iff (!rst_n)
        (dp_cmd.emit && dp_cmd.emit_last) |=> !busy)
        else $error("still busy after the final result word");

    a_write_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        dp_cmd.wr_pt |-> !busy)
        else $error("control point written during a computation");

endmodule

/* hw/rtl/bezier_de_casteljau_eval_split.sv */
`timescale 1ns / 1ps
// Top level of the de Casteljau Bezier evaluator/splitter.
// Depends on bdc_pkg, bdc_ctrl, bdc_datapath (which uses bdc_lane).
//
// Channel   Handshake                     Word
// -------   ---------                     ----
// input     start & !busy                 cmd, point_index, coord_x/y/z, curve_param
// result    result_valid (1-cycle strobe) out_x/y/z, curve_side, point_number, last
// config    cfg_wr_en                     cfg_wr_data (curve degree)
//
// Timing, with n the effective degree (degree clamped to MAX_POINTS-1):
//   A write word leaves busy low.
//   Evaluate/split hold busy while they issue (n+1) + n(n+1)/2 steps through the one
//   interpolation pipeline per coordinate, waiting for the pipeline to drain after
//   each of the n+1 triangle levels, then read out 1 (evaluate) or 2(n+1) (split)
//   result words.
//   Each result word shows in the cycle after its readout cycle, from the output
//   register, so the last word overlaps the first idle cycle.
//   Reset clears the control points to zero and sets degree to 3.
//   The receiver cannot stall: every strobe is a delivered word.

module bezier_de_casteljau_eval_split
    import bdc_pkg::*;
#(
    parameter int MAX_POINTS  = MAX_POINTS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [CMD_W-1:0]              cmd,
    input  logic [PIDX_W-1:0]             point_index,
    input  logic signed [COORD_WIDTH-1:0] coord_x,
    input  logic signed [COORD_WIDTH-1:0] coord_y,
    input  logic signed [COORD_WIDTH-1:0] coord_z,
    input  logic [PARAM_W-1:0]            curve_param,
    input  logic                          cfg_wr_en,
    input  logic [DEG_W-1:0]              cfg_wr_data,
    output logic                          result_valid,
    output logic signed [COORD_WIDTH-1:0] out_x,
    output logic signed [COORD_WIDTH-1:0] out_y,
    output logic signed [COORD_WIDTH-1:0] out_z,
    output logic                          curve_side,
    output logic [PNUM_W-1:0]             point_number,
    output logic                          last
);

    dp_cmd_t dp_cmd;
    logic    pipe_busy;

    // Sequencer: decodes the input word, walks the triangle level by level,
    // waits for the pipeline to drain between levels, then reads out results.
    bdc_ctrl #(
        .MAX_POINTS(MAX_POINTS)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .cmd        (cmd),
        .point_index(point_index),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .pipe_busy  (pipe_busy),
        .busy       (busy),
        .dp_cmd     (dp_cmd)
    );

    // Datapath: per-coordinate stores and the fetch / subtract / multiply /
    // add-and-write-back pipeline; the left and right subcurves are captured
    // as each level's first and last results are written back.
    bdc_datapath #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_WIDTH(COORD_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .dp_cmd      (dp_cmd),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .curve_param (curve_param),
        .pipe_busy   (pipe_busy),
        .result_valid(result_valid),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .curve_side  (curve_side),
        .point_number(point_number),
        .last        (last)
    );

endmodule
